[src/assert_macros.svh]
// Assertion macros used by the printf specifier parser core.
// Clocked on clk_i with the active-low reset rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SPP_ASSERT_NEVER(lbl, expr, msg) \
  `SPP_ASSERT(lbl, !(expr), msg)
`else
`define SPP_ASSERT(lbl, prop, msg)
`define SPP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[src/spp_pkg.sv]
// Types, codes and character decode functions of the printf specifier parser.
// Has no dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spp_pkg;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_FLAGS = 3'd0,
    PH_WIDTH = 3'd1,
    PH_PREC  = 3'd2,
    PH_CONV  = 3'd3,
    PH_AFTH  = 3'd4,
    PH_AFTL  = 3'd5
  } phase_e;

  // Length modifier codes.
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenH    = 3'd1;
  localparam logic [2:0] LenHH   = 3'd2;
  localparam logic [2:0] LenL    = 3'd3;
  localparam logic [2:0] LenLL   = 3'd4;
  localparam logic [2:0] LenJ    = 3'd5;
  localparam logic [2:0] LenZ    = 3'd6;

  localparam int unsigned ResultBits = 45;
  localparam int unsigned TdataOutW  = 48;

  // One accepted input item.
  typedef struct packed {
    logic       first;
    logic [7:0] ch;
  } item_t;

  // One result item, first field in the highest bits.
  typedef struct packed {
    logic [3:0]  conversion;
    logic        precision_given;
    logic [15:0] precision_value;
    logic [15:0] field_width;
    logic [2:0]  length_mod;
    logic [4:0]  option_flags;
  } result_t;

  // Option flag bit for a character, zero if it is no flag.
  function automatic logic [4:0] flag_bit(input logic [7:0] c);
    logic [4:0] f;
    f = 5'b0;
    case (c)
      "0":     f = 5'b00001;
      "+":     f = 5'b00010;
      "-":     f = 5'b00100;
      " ":     f = 5'b01000;
      "#":     f = 5'b10000;
      default: f = 5'b0;
    endcase
    return f;
  endfunction

  // Conversion type code, zero for an unknown character.
  function automatic logic [3:0] conv_code(input logic [7:0] c);
    logic [3:0] k;
    k = 4'd0;
    case (c)
      "s":     k = 4'd1;
      "S":     k = 4'd2;
      "p":     k = 4'd3;
      "d":     k = 4'd4;
      "D":     k = 4'd5;
      "i":     k = 4'd6;
      "o":     k = 4'd7;
      "O":     k = 4'd8;
      "u":     k = 4'd9;
      "U":     k = 4'd10;
      "x":     k = 4'd11;
      "X":     k = 4'd12;
      "c":     k = 4'd13;
      "C":     k = 4'd14;
      default: k = 4'd0;
    endcase
    return k;
  endfunction

endpackage

[src/spp_in_reg.sv]
// Input register of the printf specifier parser: holds one item for the core.
// Depends on spp_pkg.
`timescale 1ns / 1ps

module spp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  spp_pkg::item_t  in_item_i,
  input  logic            consume_i,
  output logic            valid_o,
  output spp_pkg::item_t  item_o
);

  logic           valid_d, valid_q;
  logic           load;
  spp_pkg::item_t item_q;

  // A new item may enter when the slot is empty or drains this cycle.
  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[src/spp_core.sv]
// Specifier state and one-character step logic of the printf specifier parser.
// Depends on spp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spp_core #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spp_pkg::item_t   item_i,
  input  logic             step_i,
  output logic             emit_o,
  output spp_pkg::result_t result_o
);

  localparam int unsigned AccW = (NUMBER_BITS < 16) ? NUMBER_BITS : 16;
  localparam int unsigned SumW = AccW + 4;
  localparam logic [SumW-1:0] AccLimit = {4'b0, {AccW{1'b1}}};

  spp_pkg::phase_e phase_q, phase_d, ph;
  logic [4:0]      flags_q, flags_d, fl;
  logic [2:0]      len_q, len_d, ln;
  logic [AccW-1:0] wid_q, wid_d, wd;
  logic [AccW-1:0] prec_q, prec_d, pr;
  logic            dot_q, dot_d, dt;

  logic [7:0]      c;
  logic            is_digit, is_nz_digit;
  logic [3:0]      digit;
  logic [AccW-1:0] mac_in, mac_out;
  logic [SumW-1:0] mac_sum;
  logic [4:0]      fbit;

  logic            spec_clear, num_phase, pre_prec, wait_bad;

  assign c           = item_i.ch;
  assign is_digit    = (c >= "0") && (c <= "9");
  assign is_nz_digit = (c >= "1") && (c <= "9");
  assign digit       = c[3:0];
  assign fbit        = spp_pkg::flag_bit(c);

  // Effective state: a first character starts from a cleared specification.
  always_comb begin
    if (item_i.first) begin
      ph = spp_pkg::PH_FLAGS;
      fl = 5'b0;
      ln = spp_pkg::LenNone;
      wd = '0;
      pr = '0;
      dt = 1'b0;
    end else begin
      ph = phase_q;
      fl = flags_q;
      ln = len_q;
      wd = wid_q;
      pr = prec_q;
      dt = dot_q;
    end
  end

  // Times-ten accumulate with saturation; width and precision share it.
  assign mac_in  = (ph == spp_pkg::PH_PREC) ? pr :
                   (ph == spp_pkg::PH_WIDTH) ? wd : '0;
  assign mac_sum = {1'b0, mac_in, 3'b0} + {3'b0, mac_in, 1'b0} + {{AccW{1'b0}}, digit};
  assign mac_out = (mac_sum > AccLimit) ? {AccW{1'b1}} : mac_sum[AccW-1:0];

  // Next state and emit decision.
  always_comb begin
    phase_d = ph;
    flags_d = fl;
    len_d   = ln;
    wid_d   = wd;
    prec_d  = pr;
    dot_d   = dt;
    emit_o  = 1'b0;
    case (ph)
      spp_pkg::PH_FLAGS, spp_pkg::PH_WIDTH, spp_pkg::PH_PREC: begin
        if (ph == spp_pkg::PH_FLAGS && fbit != 5'b0) begin
          flags_d = fl | fbit;
        end else if (ph == spp_pkg::PH_FLAGS && is_nz_digit) begin
          wid_d   = mac_out;
          phase_d = spp_pkg::PH_WIDTH;
        end else if (ph == spp_pkg::PH_WIDTH && is_digit) begin
          wid_d = mac_out;
        end else if (ph == spp_pkg::PH_PREC && is_digit) begin
          prec_d = mac_out;
        end else if (ph != spp_pkg::PH_PREC && c == ".") begin
          dot_d   = 1'b1;
          prec_d  = '0;
          phase_d = spp_pkg::PH_PREC;
        end else if (c == "h") begin
          len_d   = spp_pkg::LenH;
          phase_d = spp_pkg::PH_AFTH;
        end else if (c == "l") begin
          len_d   = spp_pkg::LenL;
          phase_d = spp_pkg::PH_AFTL;
        end else if (c == "j") begin
          len_d   = spp_pkg::LenJ;
          phase_d = spp_pkg::PH_CONV;
        end else if (c == "z") begin
          len_d   = spp_pkg::LenZ;
          phase_d = spp_pkg::PH_CONV;
        end else begin
          emit_o = 1'b1;
        end
      end
      spp_pkg::PH_AFTH: begin
        if (c == "h") begin
          len_d   = spp_pkg::LenHH;
          phase_d = spp_pkg::PH_CONV;
        end else begin
          emit_o = 1'b1;
        end
      end
      spp_pkg::PH_AFTL: begin
        if (c == "l") begin
          len_d   = spp_pkg::LenLL;
          phase_d = spp_pkg::PH_CONV;
        end else begin
          emit_o = 1'b1;
        end
      end
      default: begin
        emit_o = 1'b1;
      end
    endcase
    // A result returns the specification to its reset state.
    if (emit_o) begin
      phase_d = spp_pkg::PH_FLAGS;
      flags_d = 5'b0;
      len_d   = spp_pkg::LenNone;
      wid_d   = '0;
      prec_d  = '0;
      dot_d   = 1'b0;
    end
  end

  // Result fields come from the state gathered before the conversion char.
  always_comb begin
    result_o.option_flags    = fl;
    result_o.length_mod      = ln;
    result_o.field_width     = 16'(wd);
    result_o.precision_value = 16'(pr);
    result_o.precision_given = dt;
    result_o.conversion      = spp_pkg::conv_code(c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= spp_pkg::PH_FLAGS;
      flags_q <= 5'b0;
      len_q   <= spp_pkg::LenNone;
      wid_q   <= '0;
      prec_q  <= '0;
      dot_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      wid_q   <= wid_d;
      prec_q  <= prec_d;
      dot_q   <= dot_d;
    end
  end

  // Conditions on the stored specification used by the checks below.
  assign spec_clear = (phase_q == spp_pkg::PH_FLAGS) && (wid_q == '0) && !dot_q;
  assign num_phase  = (phase_q == spp_pkg::PH_FLAGS) || (phase_q == spp_pkg::PH_WIDTH) ||
                      (phase_q == spp_pkg::PH_PREC);
  assign pre_prec   = (phase_q == spp_pkg::PH_FLAGS) || (phase_q == spp_pkg::PH_WIDTH);
  assign wait_bad   = ((phase_q == spp_pkg::PH_AFTH) && (len_q != spp_pkg::LenH)) ||
                      ((phase_q == spp_pkg::PH_AFTL) && (len_q != spp_pkg::LenL));

  // Consistency of the stored specification.
  `SPP_ASSERT(a_emit_clears, step_i && emit_o |=> spec_clear, "state not cleared after result")
  `SPP_ASSERT_NEVER(a_len_early, num_phase && len_q != spp_pkg::LenNone, "length set early")
  `SPP_ASSERT_NEVER(a_dot_early, pre_prec && dot_q, "dot seen in flags or width phase")
  `SPP_ASSERT_NEVER(a_len_wait, wait_bad, "pending modifier mismatch")

endmodule

[src/spp_out_reg.sv]
// Output register of the printf specifier parser: holds one result item.
// Depends on spp_pkg.
`timescale 1ns / 1ps

module spp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  spp_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output spp_pkg::result_t result_o
);

  logic             valid_d, valid_q;
  spp_pkg::result_t result_q;

  // The slot can take a result when empty or being emptied now.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[src/printf_spec_parser.sv]
// Top level of the printf specifier parser: input register, step core, output register.
// Depends on spp_pkg, spp_in_reg, spp_core and spp_out_reg.
//
//   channel   direction  contents
//   s_axis    in         tdata: ch[7:0]; tuser: first
//   m_axis    out        tdata: flags, length, width, precision, given, conversion
//
// Each character is one core step; one item per cycle, unless the output stalls.
// A result is offered by the output register once its character has stepped the core.
// A character that yields a result waits in the input register while the
// output register is full and not being taken, and the input is not ready
// meanwhile; a character that yields no result never waits.
// Reset clears the handshake state and the specification.
`timescale 1ns / 1ps

module printf_spec_parser #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] option_flags, [7:5] length_mod, [23:8] field_width,
  // [39:24] precision_value, [40] precision_given, [44:41] conversion, [47:45] zero
  output logic [47:0] m_axis_tdata
);

  spp_pkg::item_t   in_item, cur_item;
  spp_pkg::result_t step_res, out_res;
  logic             cur_valid, emit, out_free, step;

  assign in_item.ch    = s_axis_tdata;
  assign in_item.first = s_axis_tuser;

  // An item steps when it makes no result or the output slot can take it.
  assign step = cur_valid && (!emit || out_free);

  spp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .consume_i  (step),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  spp_core #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (cur_item),
    .step_i   (step),
    .emit_o   (emit),
    .result_o (step_res)
  );

  spp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_res)
  );

  assign m_axis_tdata = {3'b0, out_res};

endmodule
